### sv/fdsa_pkg.sv
`timescale 1ns / 1ps
package fdsa_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CountW = 7;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_DUP   = 5'd1,
    OP_DROP  = 5'd2,
    OP_SWAP  = 5'd3,
    OP_OVER  = 5'd4,
    OP_ROT   = 5'd5,
    OP_ADD   = 5'd6,
    OP_SUB   = 5'd7,
    OP_MUL   = 5'd8,
    OP_DIV   = 5'd9,
    OP_LT    = 5'd10,
    OP_LE    = 5'd11,
    OP_GT    = 5'd12,
    OP_GE    = 5'd13,
    OP_EQ    = 5'd14,
    OP_NE    = 5'd15,
    OP_PRINT = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_EXEC,
    ST_DIV,
    ST_PUSH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic signed [31:0] literal;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic signed [31:0] top_value;
    logic [6:0]  stack_count;
    logic        print_valid;
    logic signed [31:0] print_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic pop;
    logic exec;
    logic div_start;
    logic push;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ovf;
    logic pops_left;
    logic pushes_left;
    logic is_div;
    logic div_done;
  } stat_t;

  function automatic logic [1:0] pop_cnt(input logic [4:0] k);
    case (k)
      OP_PUSH: pop_cnt = 2'd0;
      OP_DUP, OP_DROP, OP_PRINT: pop_cnt = 2'd1;
      OP_ROT: pop_cnt = 2'd3;
      default: pop_cnt = (k <= 5'd16) ? 2'd2 : 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] push_cnt(input logic [4:0] k);
    case (k)
      OP_PUSH: push_cnt = 2'd1;
      OP_DROP, OP_PRINT: push_cnt = 2'd0;
      OP_DUP, OP_SWAP: push_cnt = 2'd2;
      OP_OVER, OP_ROT: push_cnt = 2'd3;
      default: push_cnt = (k <= 5'd16) ? 2'd1 : 2'd0;
    endcase
  endfunction

endpackage

### sv/fdsa_ctrl.sv
`timescale 1ns / 1ps
module fdsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  fdsa_pkg::stat_t stat_i,
  output fdsa_pkg::cmd_t  cmd_o
);

  fdsa_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fdsa_pkg::ST_IDLE: if (in_valid_i) state_d = fdsa_pkg::ST_POP;
      fdsa_pkg::ST_POP: begin
        if (stat_i.ovf) state_d = fdsa_pkg::ST_OUT;
        else if (!stat_i.pops_left) state_d = fdsa_pkg::ST_EXEC;
      end
      fdsa_pkg::ST_EXEC: state_d = stat_i.is_div ? fdsa_pkg::ST_DIV : fdsa_pkg::ST_PUSH;
      fdsa_pkg::ST_DIV: if (stat_i.div_done) state_d = fdsa_pkg::ST_PUSH;
      fdsa_pkg::ST_PUSH: if (!stat_i.pushes_left) state_d = fdsa_pkg::ST_OUT;
      fdsa_pkg::ST_OUT: if (!out_valid_q || !out_stall_i) state_d = fdsa_pkg::ST_IDLE;
      default: state_d = fdsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fdsa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      fdsa_pkg::ST_POP: cmd_o.pop = !stat_i.ovf && stat_i.pops_left;
      fdsa_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.div_start = stat_i.is_div;
      end
      fdsa_pkg::ST_PUSH: cmd_o.push = stat_i.pushes_left;
      fdsa_pkg::ST_OUT: cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdsa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/fdsa_div.sv
`timescale 1ns / 1ps
module fdsa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  // one quotient bit per cycle, restoring on magnitudes
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? 32'd0 - a_i : a_i;
      den_d = b_i[31] ? 32'd0 - b_i : b_i;
      neg_d = a_i[31] ^ b_i[31];
      busy_d = 1'b1;
      cnt_d = 6'd0;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      // flag done once the last quotient bit is in
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 32'd0 - quo_q : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

endmodule

### sv/fdsa_dp.sv
`timescale 1ns / 1ps
module fdsa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdsa_pkg::in_item_t  in_item_i,
  input  fdsa_pkg::cmd_t      cmd_i,
  output fdsa_pkg::stat_t     stat_o,
  output fdsa_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = fdsa_pkg::AddrW;

  logic [31:0] mem [fdsa_pkg::StackDepth];
  logic [31:0] rd_q, top_rd;
  logic        rd_pend_q;
  logic [fdsa_pkg::CountW-1:0] depth_q, depth_d;
  logic [4:0]  kind_q;
  logic [31:0] lit_q;
  logic [1:0]  pops_q, pushes_q, slot_q;
  logic [1:0]  err_q;
  logic        ovf_q, pv_q;
  logic [31:0] pval_q;
  logic [31:0] opd_q [3];
  logic [31:0] res_q [3];
  logic [31:0] a, b, q_div, mul_r, r0;
  logic        lt_ab, lt_ba, div_done;
  logic [1:0]  pc, qc, avail;
  logic [fdsa_pkg::CountW:0] newd;
  logic [AW-1:0] wr_addr, rd_addr;
  fdsa_pkg::out_item_t out_q;

  assign pc = fdsa_pkg::pop_cnt(in_item_i.kind);
  assign qc = fdsa_pkg::push_cnt(in_item_i.kind);
  assign avail = (depth_q < {5'd0, pc}) ? depth_q[1:0] : pc;
  assign newd = {1'b0, depth_q} - {6'd0, avail} + {6'd0, qc};

  assign a = opd_q[0];
  assign b = opd_q[1];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign mul_r = a * b;

  fdsa_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start && b != 32'd0),
    .a_i(a), .b_i(b),
    .done_o(div_done), .quot_o(q_div)
  );

  always_comb begin
    r0 = '0;
    case (kind_q)
      fdsa_pkg::OP_PUSH: r0 = lit_q;
      fdsa_pkg::OP_DUP, fdsa_pkg::OP_OVER: r0 = a;
      fdsa_pkg::OP_SWAP, fdsa_pkg::OP_ROT: r0 = b;
      fdsa_pkg::OP_ADD: r0 = a + b;
      fdsa_pkg::OP_SUB: r0 = a - b;
      fdsa_pkg::OP_MUL: r0 = mul_r;
      fdsa_pkg::OP_LT: r0 = {32{lt_ab}};
      fdsa_pkg::OP_LE: r0 = {32{!lt_ba}};
      fdsa_pkg::OP_GT: r0 = {32{lt_ba}};
      fdsa_pkg::OP_GE: r0 = {32{!lt_ab}};
      fdsa_pkg::OP_EQ: r0 = {32{a == b}};
      fdsa_pkg::OP_NE: r0 = {32{a != b}};
      default: r0 = '0;
    endcase
  end

  assign rd_addr = depth_q[AW-1:0] - AW'(1);
  assign wr_addr = depth_q[AW-1:0];

  // drop the cell on the data cycle of a pop, once its read is back
  always_comb begin
    depth_d = depth_q;
    if (cmd_i.pop && rd_pend_q) depth_d = depth_q - 7'd1;
    else if (cmd_i.push) depth_d = depth_q + 7'd1;
  end

  // memory read port: top-1 entry, registered
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (cmd_i.push) mem[wr_addr] <= res_q[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      pops_q <= '0;
      pushes_q <= '0;
      ovf_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      if (cmd_i.load) begin
        ovf_q <= in_item_i.kind <= 5'd16 && newd > (fdsa_pkg::CountW+1)'(fdsa_pkg::StackDepth);
        pops_q <= (in_item_i.kind <= 5'd16) ? pc : 2'd0;
        pushes_q <= (in_item_i.kind <= 5'd16) ? qc : 2'd0;
        rd_pend_q <= 1'b0;
      end else if (cmd_i.pop) begin
        // a pop from a nonempty stack is an address step, then a registered data step; an empty stack gives no read
        if (!rd_pend_q && depth_q != '0) rd_pend_q <= 1'b1;
        else begin
          rd_pend_q <= 1'b0;
          pops_q <= pops_q - 2'd1;
        end
      end else if (cmd_i.push) begin
        pushes_q <= pushes_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_item_i.kind;
      lit_q <= in_item_i.literal;
      err_q <= fdsa_pkg::ERR_NONE;
      pv_q <= 1'b0;
      pval_q <= '0;
      slot_q <= '0;
      opd_q[0] <= '0; opd_q[1] <= '0; opd_q[2] <= '0;
    end
    if (cmd_i.pop && rd_pend_q) opd_q[pops_q - 2'd1] <= rd_q;
    if (cmd_i.pop && !rd_pend_q && depth_q == '0) begin
      opd_q[pops_q - 2'd1] <= '0;
      err_q <= fdsa_pkg::ERR_UNDER;
    end
    if (cmd_i.exec) begin
      res_q[0] <= r0;
      res_q[1] <= (kind_q == fdsa_pkg::OP_ROT) ? opd_q[2] : (kind_q == fdsa_pkg::OP_OVER) ? b : a;
      res_q[2] <= a;
      if (kind_q == fdsa_pkg::OP_PRINT) begin
        pv_q <= 1'b1;
        pval_q <= a;
      end
      if (kind_q == fdsa_pkg::OP_DIV && b == 32'd0 && err_q == fdsa_pkg::ERR_NONE)
        err_q <= fdsa_pkg::ERR_DIV0;
    end
    if (div_done) res_q[0] <= q_div;
    if (cmd_i.push) begin
      slot_q <= slot_q + 2'd1;
    end
    if (cmd_i.out_load) begin
      out_q.error_code <= ovf_q ? fdsa_pkg::ERR_OVER : err_q;
      out_q.stack_count <= depth_q;
      out_q.print_valid <= ovf_q ? 1'b0 : pv_q;
      out_q.print_value <= ovf_q ? 32'd0 : pval_q;
      out_q.top_value <= top_rd;
    end
  end

  // top of stack for the result: the registered read issued after the op
  assign top_rd = (depth_q == '0) ? 32'd0 : rd_q;
  assign out_item_o = out_q;

  assign stat_o.ovf = ovf_q;
  assign stat_o.pops_left = pops_q != 2'd0;
  assign stat_o.pushes_left = pushes_q != 2'd0;
  assign stat_o.is_div = kind_q == fdsa_pkg::OP_DIV && b != 32'd0;
  assign stat_o.div_done = div_done;

endmodule

### sv/forth_data_stack_alu_top.sv
`timescale 1ns / 1ps
// Forth data stack with ALU: one stack instruction per input transfer, one
// result transfer per instruction. An instruction steps through the idle,
// pop, execute, push and output states; each operand is a registered memory
// read from the stack, an operand missing on underflow reads as zero, and
// result cells are pushed one by one. An overflowing instruction goes from pop
// to output, and a divide by a nonzero value waits for the bit-serial divider.
// A stalled result holds the next instruction in its output state. The stack
// holds 64 cells in a single-port-write, registered-read memory.
module forth_data_stack_alu_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fdsa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdsa_pkg::out_item_t out_data_o
);

  fdsa_pkg::cmd_t  cmd;
  fdsa_pkg::stat_t stat;

  fdsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  fdsa_dp u_dp (
    .clk_i, .rst_ni, .in_item_i(in_data_i), .cmd_i(cmd), .stat_o(stat),
    .out_item_o(out_data_o)
  );

endmodule

### sv/fdsa_checker.sv
`timescale 1ns / 1ps
module fdsa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fdsa_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.print_valid |-> out_data_o.print_value == 32'd0)
    else $error("print value without print");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stack_count == 7'd0 |-> out_data_o.top_value == 32'd0)
    else $error("empty stack has nonzero top");

endmodule

bind forth_data_stack_alu_top fdsa_checker u_fdsa_checker (.*);

### tb/forth_data_stack_alu_top_tb.sv
`timescale 1ns / 1ps
module forth_data_stack_alu_top_tb;

  localparam int unsigned NumRandom = 350;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic                check_fixed;
    fdsa_pkg::in_item_t  item;
    fdsa_pkg::out_item_t fixed;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  fdsa_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  fdsa_pkg::out_item_t out_data_o;

  forth_data_stack_alu_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted stack image.
  logic [31:0] cells [fdsa_pkg::StackDepth];
  int unsigned depth_q;
  fdsa_pkg::out_item_t pending_results [$];
  int unsigned failures;
  logic        idle_enable;

  function automatic logic lt_s(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic fdsa_pkg::out_item_t execute_op(fdsa_pkg::in_item_t it);
    fdsa_pkg::out_item_t r;
    logic [31:0] opd [3];
    logic [31:0] res [3];
    logic [1:0]  err;
    int unsigned p;
    int unsigned q;
    int unsigned avail;
    logic [31:0] a;
    logic [31:0] b;
    r = '0;
    err = fdsa_pkg::ERR_NONE;
    opd = '{default: '0};
    res = '{default: '0};
    if (it.kind <= fdsa_pkg::OP_PRINT) begin
      p = fdsa_pkg::pop_cnt(it.kind);
      q = fdsa_pkg::push_cnt(it.kind);
      avail = (depth_q < p) ? depth_q : p;
      if (depth_q - avail + q > fdsa_pkg::StackDepth) begin
        err = fdsa_pkg::ERR_OVER;
      end else begin
        for (int i = p; i > 0; i--) begin
          if (depth_q > 0) begin
            depth_q--;
            opd[i-1] = cells[depth_q];
          end else begin
            err = fdsa_pkg::ERR_UNDER;
          end
        end
        a = opd[0];
        b = opd[1];
        case (fdsa_pkg::op_e'(it.kind))
          fdsa_pkg::OP_PUSH: res[0] = it.literal;
          fdsa_pkg::OP_DUP:  begin res[0] = a; res[1] = a; end
          fdsa_pkg::OP_SWAP: begin res[0] = b; res[1] = a; end
          fdsa_pkg::OP_OVER: begin res[0] = a; res[1] = b; res[2] = a; end
          fdsa_pkg::OP_ROT:  begin res[0] = b; res[1] = opd[2]; res[2] = a; end
          fdsa_pkg::OP_ADD:  res[0] = a + b;
          fdsa_pkg::OP_SUB:  res[0] = a - b;
          fdsa_pkg::OP_MUL:  res[0] = a * b;
          fdsa_pkg::OP_DIV: begin
            if (b == 0) begin
              if (err == fdsa_pkg::ERR_NONE) err = fdsa_pkg::ERR_DIV0;
            end else if (a == 32'h8000_0000 && b == '1) begin
              res[0] = a;
            end else begin
              res[0] = $signed(a) / $signed(b);
            end
          end
          fdsa_pkg::OP_LT: res[0] = {32{lt_s(a, b)}};
          fdsa_pkg::OP_LE: res[0] = {32{!lt_s(b, a)}};
          fdsa_pkg::OP_GT: res[0] = {32{lt_s(b, a)}};
          fdsa_pkg::OP_GE: res[0] = {32{!lt_s(a, b)}};
          fdsa_pkg::OP_EQ: res[0] = {32{a == b}};
          fdsa_pkg::OP_NE: res[0] = {32{a != b}};
          fdsa_pkg::OP_PRINT: begin
            r.print_valid = 1'b1;
            r.print_value = a;
          end
          default: ;
        endcase
        for (int i = 0; i < q; i++) begin
          cells[depth_q] = res[i];
          depth_q++;
        end
      end
    end
    r.error_code = err;
    r.top_value = (depth_q > 0) ? cells[depth_q-1] : '0;
    r.stack_count = depth_q[6:0];
    return r;
  endfunction

  // Result checker and watchdog.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    fdsa_pkg::out_item_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          e = pending_results.pop_front();
          if (out_data_o.error_code !== e.error_code) begin
            $error("error_code exp %0d got %0d", e.error_code, out_data_o.error_code);
            failures++;
          end
          if (out_data_o.top_value !== e.top_value) begin
            $error("top_value exp %0d got %0d", e.top_value, out_data_o.top_value);
            failures++;
          end
          if (out_data_o.stack_count !== e.stack_count) begin
            $error("stack_count exp %0d got %0d", e.stack_count, out_data_o.stack_count);
            failures++;
          end
          if (out_data_o.print_valid !== e.print_valid) begin
            $error("print_valid exp %0d got %0d", e.print_valid, out_data_o.print_valid);
            failures++;
          end
          if (out_data_o.print_value !== e.print_value) begin
            $error("print_value exp %0d got %0d", e.print_value, out_data_o.print_value);
            failures++;
          end
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= idle_enable && ($urandom_range(99) < 24);
  end

  task automatic send_item(fdsa_pkg::in_item_t it, logic has_fixed,
                           fdsa_pkg::out_item_t fx);
    fdsa_pkg::out_item_t pred;
    while (idle_enable && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    pred = execute_op(it);
    // hold typed rows to their typed result; the predictor still tracks the stack
    pending_results.push_back(has_fixed ? fx : pred);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic fdsa_pkg::in_item_t mk(fdsa_pkg::op_e k, logic [31:0] v);
    fdsa_pkg::in_item_t it;
    it.kind = k;
    it.literal = v;
    return it;
  endfunction

  function automatic fdsa_pkg::out_item_t rs(logic [1:0] e, logic [31:0] t, logic [6:0] c,
                                             logic pv, logic [31:0] v);
    return {e, t, c, pv, v};
  endfunction

  stim_row_t directed [] = '{
    '{1'b1, mk(fdsa_pkg::OP_DROP, 0), rs(fdsa_pkg::ERR_UNDER, 0, 0, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_PRINT, 0), rs(fdsa_pkg::ERR_UNDER, 0, 0, 1, 0)},
    '{1'b1, mk(fdsa_pkg::OP_ADD, 0), rs(fdsa_pkg::ERR_UNDER, 0, 1, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_DIV, 0), rs(fdsa_pkg::ERR_UNDER, 0, 1, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_PUSH, 32'h8000_0000),
      rs(fdsa_pkg::ERR_NONE, 32'h8000_0000, 2, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_PUSH, 32'hFFFF_FFFF),
      rs(fdsa_pkg::ERR_NONE, 32'hFFFF_FFFF, 3, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_DIV, 0), rs(fdsa_pkg::ERR_NONE, 32'h8000_0000, 2, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_PUSH, 0), rs(fdsa_pkg::ERR_NONE, 0, 3, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_DIV, 0), rs(fdsa_pkg::ERR_DIV0, 0, 2, 0, 0)},
    '{1'b1, mk(fdsa_pkg::OP_PUSH, 32'h7FFF_FFFF),
      rs(fdsa_pkg::ERR_NONE, 32'h7FFF_FFFF, 3, 0, 0)},
    '{1'b0, mk(fdsa_pkg::OP_DUP, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_ADD, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_PUSH, 32'h5A5A_A5A5), '0},
    '{1'b0, mk(fdsa_pkg::OP_OVER, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_ROT, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_SWAP, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_SUB, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_MUL, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_LT, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_OVER, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_LE, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_GT, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_GE, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_EQ, 0), '0},
    '{1'b0, mk(fdsa_pkg::OP_NE, 0), '0},
    '{1'b0, mk(fdsa_pkg::op_e'(5'd31), 32'h1234_5678), '0}
  };

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(7);
      4: return -$urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic fdsa_pkg::in_item_t rand_item();
    fdsa_pkg::in_item_t it;
    int unsigned sel;
    sel = $urandom_range(99);
    it.literal = rand_value();
    if (sel < 3) it.kind = $urandom_range(31, 17);
    // keep the stack mostly mid-deep, but visit both ends
    else if (depth_q < 2 && sel < 70) it.kind = fdsa_pkg::OP_PUSH;
    else if (sel < 35) it.kind = fdsa_pkg::OP_PUSH;
    else it.kind = $urandom_range(fdsa_pkg::OP_PRINT, fdsa_pkg::OP_DUP);
    return it;
  endfunction

  initial begin
    failures = 0;
    idle_enable = 1'b1;
    depth_q = 0;
    foreach (cells[i]) cells[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_item(directed[i].item, directed[i].check_fixed,
                                    directed[i].fixed);
    // fill to overflow, then drain
    while (depth_q < fdsa_pkg::StackDepth)
      send_item(mk(fdsa_pkg::OP_PUSH, $urandom), 1'b0, '0);
    send_item(mk(fdsa_pkg::OP_OVER, 0), 1'b0, '0);
    send_item(mk(fdsa_pkg::OP_PUSH, 1), 1'b0, '0);
    send_item(mk(fdsa_pkg::OP_DROP, 0), 1'b0, '0);
    send_item(mk(fdsa_pkg::OP_DUP, 0), 1'b0, '0);
    send_item(mk(fdsa_pkg::OP_ROT, 0), 1'b0, '0);
    while (depth_q > 0) send_item(mk(fdsa_pkg::OP_PRINT, 0), 1'b0, '0);
    for (int n = 0; n < NumRandom; n++) begin
      if (n >= 150 && n < 250) idle_enable = 1'b0;
      else idle_enable = 1'b1;
      send_item(rand_item(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    idle_enable = 1'b1;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("forth_data_stack_alu_top test passed");
    end else begin
      $display("forth_data_stack_alu_top test failed");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("forth_data_stack_alu_top test failed");
    $finish;
  end

endmodule

### forth_data_stack_alu_top.f
sv/fdsa_pkg.sv
sv/fdsa_ctrl.sv
sv/fdsa_div.sv
sv/fdsa_dp.sv
sv/forth_data_stack_alu_top.sv
sv/fdsa_checker.sv
tb/forth_data_stack_alu_top_tb.sv
